>>> rtl/spcr_pkg.sv
// Package: types, constants and helpers shared by the SysEx PTZ receiver.
`timescale 1ns / 1ps
`default_nettype none

package spcr_pkg;

    // Frame size limit, counting F0 and F7
    localparam int MAX_FRAME = 256;
    localparam int COUNT_W   = $clog2(MAX_FRAME + 1);

    // Result queue
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_PAN_LOWER  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAN_UPPER  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TILT_LOWER = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TILT_UPPER = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ZOOM_LOWER = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ZOOM_UPPER = 3'd5;

    // MIDI bytes
    localparam logic [7:0] SYX_START = 8'hF0;
    localparam logic [7:0] SYX_END   = 8'hF7;
    localparam logic [7:0] RT_FIRST  = 8'hF8;

    // Frame payload codes
    localparam logic [6:0] PTZ_VERSION = 7'h01;
    localparam logic [6:0] CMD_CAPS    = 7'h01;
    localparam logic [6:0] CMD_SET     = 7'h02;
    localparam logic [6:0] CTRL_PAN    = 7'h01;
    localparam logic [6:0] CTRL_TILT   = 7'h02;
    localparam logic [6:0] CTRL_ZOOM   = 7'h03;

    // byte_count seen at F7 for a seven-byte frame and for a set frame
    localparam logic [COUNT_W-1:0] BC_MIN_FRAME = COUNT_W'(6);
    localparam logic [COUNT_W-1:0] BC_SET_FRAME = COUNT_W'(13);
    localparam logic [COUNT_W-1:0] BC_HDR_FIRST = COUNT_W'(1);
    localparam logic [COUNT_W-1:0] BC_HDR_LAST  = COUNT_W'(4);
    localparam logic [COUNT_W-1:0] BC_BODY_FIRST = COUNT_W'(5);
    localparam logic [COUNT_W-1:0] BC_BODY_LAST  = COUNT_W'(12);
    localparam logic [COUNT_W-1:0] BC_LIMIT      = COUNT_W'(MAX_FRAME);

    // Result kinds
    localparam logic [1:0] KIND_CAPS    = 2'd0;
    localparam logic [1:0] KIND_BAD     = 2'd1;
    localparam logic [1:0] KIND_PANTILT = 2'd2;
    localparam logic [1:0] KIND_ZOOM    = 2'd3;

    typedef struct packed {
        logic       action;
        logic [7:0] midi_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] pan_out;
        logic signed [31:0] tilt_out;
        logic [15:0]        zoom_out;
        logic               last;
    } out_item_t;

    // Expected header bytes 1..4: 7D 'P' 'T' 'Z'
    function automatic logic [6:0] hdr_byte(input logic [1:0] idx);
        logic [6:0] b;
        case (idx)
            2'd0:    b = 7'h7D;
            2'd1:    b = 7'h50;
            2'd2:    b = 7'h54;
            default: b = 7'h5A;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

>>> rtl/sysex_ptz_command_receiver.sv
// Top level: MIDI SysEx PTZ command receiver with clamped write results.
`timescale 1ns / 1ps
`default_nettype none

//  channel | beat                      | handshake
//  --------+---------------------------+-----------------------------
//  in      | in_data  (action, byte)   | in_valid / in_stall
//  out     | out_data (kind..last)     | out_valid / out_stall
//  cfg     | cfg_index, cfg_data       | cfg_we, no wait
//
// One input beat per cycle while in_stall is low. A beat is registered, then
// decoded against the frame state and pushed (0..2 results) into a 4-entry
// result queue; results leave from the queue register that the decode wrote.
// in_stall rises only while the input register holds a beat and the queue
// has fewer than two free entries. Reset clears frame state, targets,
// dirty flags and the queue; config registers reset to full ranges.
module sysex_ptz_command_receiver (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          in_valid,
    output logic                         in_stall,
    input  wire spcr_pkg::in_item_t      in_data,
    output logic                         out_valid,
    input  wire                          out_stall,
    output spcr_pkg::out_item_t          out_data,
    input  wire                          cfg_we,
    input  wire [spcr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire [31:0]                   cfg_data
);
    import spcr_pkg::*;

    // Configuration
    logic signed [31:0] pan_lo_reg, pan_hi_reg, tilt_lo_reg, tilt_hi_reg;
    logic [15:0]        zoom_lo_reg, zoom_hi_reg;

    // Input register
    logic     in_valid_reg;
    in_item_t in_reg;

    // Frame and target state
    logic               in_frame_reg, in_frame_next;
    logic [COUNT_W-1:0] byte_count_reg, byte_count_next;
    logic               header_ok_reg, header_ok_next;
    logic [6:0]         frame_bytes_reg [8];
    logic [31:0]        pan_target_reg, pan_target_next;
    logic [31:0]        tilt_target_reg, tilt_target_next;
    logic [31:0]        zoom_target_reg, zoom_target_next;
    logic               pantilt_dirty_reg, pantilt_dirty_next;
    logic               zoom_dirty_reg, zoom_dirty_next;

    // Result queue
    out_item_t          queue_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;

    // Processing stage
    logic               proc;
    logic               pop;
    logic               fb_we;
    logic [2:0]         fb_idx;
    logic [1:0]         n_res;
    out_item_t          res0, res1;
    logic [31:0]        set_value;
    logic signed [31:0] pan_clamped, tilt_clamped, zoom_clamped;
    logic signed [31:0] zoom_lo_s, zoom_hi_s;
    logic [7:0]         b;
    logic [1:0]         dec_kind;
    logic               dec_emit;

    // Room for two results is checked on registered count only, so the
    // input side never waits on out_stall combinationally.
    assign proc     = in_valid_reg && (count_reg <= QCNT_W'(QDEPTH - 2));
    assign in_stall = in_valid_reg && !proc;
    assign pop      = out_valid && !out_stall;
    assign out_valid = (count_reg != '0);
    assign out_data  = queue_reg[rd_ptr_reg];
    assign b         = in_reg.midi_byte;

    // 35-bit value from five 7-bit groups, LS group first; keep low 32
    assign set_value = {frame_bytes_reg[7][3:0], frame_bytes_reg[6], frame_bytes_reg[5],
                        frame_bytes_reg[4], frame_bytes_reg[3]};

    // Clamps: below lower gives lower, else above upper gives upper
    assign zoom_lo_s = $signed({16'd0, zoom_lo_reg});
    assign zoom_hi_s = $signed({16'd0, zoom_hi_reg});

    always_comb
    begin
        if ($signed(pan_target_reg) < pan_lo_reg)
            pan_clamped = pan_lo_reg;
        else if ($signed(pan_target_reg) > pan_hi_reg)
            pan_clamped = pan_hi_reg;
        else
            pan_clamped = $signed(pan_target_reg);

        if ($signed(tilt_target_reg) < tilt_lo_reg)
            tilt_clamped = tilt_lo_reg;
        else if ($signed(tilt_target_reg) > tilt_hi_reg)
            tilt_clamped = tilt_hi_reg;
        else
            tilt_clamped = $signed(tilt_target_reg);

        if ($signed(zoom_target_reg) < zoom_lo_s)
            zoom_clamped = zoom_lo_s;
        else if ($signed(zoom_target_reg) > zoom_hi_s)
            zoom_clamped = zoom_hi_s;
        else
            zoom_clamped = $signed(zoom_target_reg);
    end

    // Frame decode at F7 (result kind only; set writes handled below)
    always_comb
    begin
        dec_emit = 1'b0;
        dec_kind = KIND_BAD;
        if (byte_count_reg >= BC_MIN_FRAME && header_ok_reg)
        begin
            if (byte_count_reg == BC_MIN_FRAME)
                dec_emit = 1'b1;            // F7 sits where the command goes
            else if (frame_bytes_reg[0] != PTZ_VERSION)
                dec_emit = 1'b1;
            else if (frame_bytes_reg[1] == CMD_CAPS)
            begin
                dec_emit = 1'b1;
                dec_kind = KIND_CAPS;
            end
            else if (frame_bytes_reg[1] != CMD_SET || byte_count_reg != BC_SET_FRAME)
                dec_emit = 1'b1;
            else if (frame_bytes_reg[2] != CTRL_PAN && frame_bytes_reg[2] != CTRL_TILT
                     && frame_bytes_reg[2] != CTRL_ZOOM)
                dec_emit = 1'b1;
        end
    end

    always_comb
    begin
        in_frame_next      = in_frame_reg;
        byte_count_next    = byte_count_reg;
        header_ok_next     = header_ok_reg;
        pan_target_next    = pan_target_reg;
        tilt_target_next   = tilt_target_reg;
        zoom_target_next   = zoom_target_reg;
        pantilt_dirty_next = pantilt_dirty_reg;
        zoom_dirty_next    = zoom_dirty_reg;
        fb_we              = 1'b0;
        fb_idx             = byte_count_reg[2:0] - 3'd5;
        n_res              = 2'd0;
        res0               = '0;
        res1               = '0;

        if (proc)
        begin
            if (in_reg.action)
            begin
                // flush tick
                if (pantilt_dirty_reg)
                begin
                    res0.kind     = KIND_PANTILT;
                    res0.pan_out  = pan_clamped;
                    res0.tilt_out = tilt_clamped;
                    res0.last     = !zoom_dirty_reg;
                    pantilt_dirty_next = 1'b0;
                    if (zoom_dirty_reg)
                    begin
                        res1.kind     = KIND_ZOOM;
                        res1.zoom_out = zoom_clamped[15:0];
                        res1.last     = 1'b1;
                        n_res         = 2'd2;
                    end
                    else
                        n_res = 2'd1;
                end
                else if (zoom_dirty_reg)
                begin
                    res0.kind     = KIND_ZOOM;
                    res0.zoom_out = zoom_clamped[15:0];
                    res0.last     = 1'b1;
                    n_res         = 2'd1;
                end
                zoom_dirty_next = 1'b0;
            end
            else if (b == SYX_START)
            begin
                in_frame_next   = 1'b1;
                byte_count_next = BC_HDR_FIRST;
                header_ok_next  = 1'b1;
            end
            else if (!in_frame_reg || b >= RT_FIRST)
            begin
                // realtime bytes and stray bytes: no effect
            end
            else if (b == SYX_END)
            begin
                if (byte_count_reg < BC_LIMIT)
                begin
                    if (dec_emit)
                    begin
                        res0.kind = dec_kind;
                        res0.last = 1'b1;
                        n_res     = 2'd1;
                    end
                    else if (byte_count_reg == BC_SET_FRAME && header_ok_reg
                             && frame_bytes_reg[0] == PTZ_VERSION
                             && frame_bytes_reg[1] == CMD_SET)
                    begin
                        case (frame_bytes_reg[2])
                            CTRL_PAN:
                            begin
                                pan_target_next    = set_value;
                                pantilt_dirty_next = 1'b1;
                            end
                            CTRL_TILT:
                            begin
                                tilt_target_next   = set_value;
                                pantilt_dirty_next = 1'b1;
                            end
                            CTRL_ZOOM:
                            begin
                                zoom_target_next = set_value;
                                zoom_dirty_next  = 1'b1;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                in_frame_next = 1'b0;
            end
            else if (b[7])
                in_frame_next = 1'b0;       // other status byte aborts
            else if (byte_count_reg < BC_LIMIT)
            begin
                if (byte_count_reg >= BC_HDR_FIRST && byte_count_reg <= BC_HDR_LAST
                    && b[6:0] != hdr_byte(2'(byte_count_reg - BC_HDR_FIRST)))
                    header_ok_next = 1'b0;
                if (byte_count_reg >= BC_BODY_FIRST && byte_count_reg <= BC_BODY_LAST)
                    fb_we = 1'b1;
                byte_count_next = byte_count_reg + COUNT_W'(1);
            end
            else
                in_frame_next = 1'b0;       // oversize frame dropped
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!in_stall)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall)
            in_reg <= in_data;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pan_lo_reg  <= 32'sh8000_0000;
            pan_hi_reg  <= 32'sh7FFF_FFFF;
            tilt_lo_reg <= 32'sh8000_0000;
            tilt_hi_reg <= 32'sh7FFF_FFFF;
            zoom_lo_reg <= 16'h0000;
            zoom_hi_reg <= 16'hFFFF;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PAN_LOWER:  pan_lo_reg  <= $signed(cfg_data);
                CFG_PAN_UPPER:  pan_hi_reg  <= $signed(cfg_data);
                CFG_TILT_LOWER: tilt_lo_reg <= $signed(cfg_data);
                CFG_TILT_UPPER: tilt_hi_reg <= $signed(cfg_data);
                CFG_ZOOM_LOWER: zoom_lo_reg <= cfg_data[15:0];
                CFG_ZOOM_UPPER: zoom_hi_reg <= cfg_data[15:0];
                default:
                begin
                end
            endcase
        end
    end

    // Frame state and targets
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg      <= 1'b0;
            byte_count_reg    <= '0;
            header_ok_reg     <= 1'b0;
            pan_target_reg    <= '0;
            tilt_target_reg   <= '0;
            zoom_target_reg   <= '0;
            pantilt_dirty_reg <= 1'b0;
            zoom_dirty_reg    <= 1'b0;
        end
        else
        begin
            in_frame_reg      <= in_frame_next;
            byte_count_reg    <= byte_count_next;
            header_ok_reg     <= header_ok_next;
            pan_target_reg    <= pan_target_next;
            tilt_target_reg   <= tilt_target_next;
            zoom_target_reg   <= zoom_target_next;
            pantilt_dirty_reg <= pantilt_dirty_next;
            zoom_dirty_reg    <= zoom_dirty_next;
        end
    end

    // Frame body bytes 5..12
    always_ff @(posedge clk)
    begin
        if (fb_we)
            frame_bytes_reg[fb_idx] <= b[6:0];
    end

    // Result queue
    always_ff @(posedge clk)
    begin
        if (n_res != 2'd0)
            queue_reg[wr_ptr_reg] <= res0;
        if (n_res == 2'd2)
            queue_reg[wr_ptr_reg + QPTR_W'(1)] <= res1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + QPTR_W'(n_res);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            count_reg <= count_reg + QCNT_W'(n_res) - QCNT_W'(pop);
        end
    end

endmodule

`default_nettype wire

>>> dv/tb_top.sv
// Testbench for the SysEx PTZ command receiver: random MIDI traffic checked against a predictor.
`timescale 1ns / 1ps

// Stimulus is queued per phase by the initial block, sent beat by beat by the
// driver in random bursts, and predicted as each input beat is accepted.
// The monitor stalls the result channel on its own pattern and compares each
// accepted result beat with the oldest prediction. Clamp ranges change only
// between phases, once the receiver has drained completely.
module tb_top;

    import spcr_pkg::*;

    // Header bytes 1..4 of a PTZ frame: 7D 'P' 'T' 'Z'
    localparam logic [0:3][7:0] PTZ_HDR = {8'h7D, 8'h50, 8'h54, 8'h5A};

    // Payload codes as full data bytes
    localparam logic [7:0] VER_BYTE  = {1'b0, PTZ_VERSION};
    localparam logic [7:0] CAPS_BYTE = {1'b0, CMD_CAPS};
    localparam logic [7:0] SET_BYTE  = {1'b0, CMD_SET};

    // Random beats per phase, phases after the directed part
    localparam int PHASE_BEATS = 30;
    localparam int PHASES      = 8;

    // Idle cycles allowed after the last result before a register write
    localparam int DRAIN_CYCLES = 8;

    typedef logic [7:0] octet_q_t [$];
    typedef enum logic [1:0] {FRAME_QUIET, FRAME_CAPS, FRAME_BAD} frame_verdict_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    in_item_t             in_data   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    out_item_t            out_data;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data  = '0;

    sysex_ptz_command_receiver dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor state: clamp ranges, frame assembly, targets
    // ------------------------------------------------------------------
    logic signed [31:0] pan_lo  = 32'sh8000_0000;
    logic signed [31:0] pan_hi  = 32'sh7FFF_FFFF;
    logic signed [31:0] tilt_lo = 32'sh8000_0000;
    logic signed [31:0] tilt_hi = 32'sh7FFF_FFFF;
    logic [15:0]        zoom_lo = 16'h0000;
    logic [15:0]        zoom_hi = 16'hFFFF;

    bit          m_in_frame = 1'b0;
    int          m_count    = 0;
    bit          m_hdr_ok   = 1'b0;
    logic [7:0]  m_body [8] = '{default: 8'h00};  // version, command, control, 5 groups
    logic [31:0] pan_tgt    = '0;
    logic [31:0] tilt_tgt   = '0;
    logic [31:0] zoom_tgt   = '0;
    bit          pt_dirty   = 1'b0;
    bit          z_dirty    = 1'b0;

    in_item_t  pending_beats [$];     // input beats not yet driven
    out_item_t ptz_results_due [$];   // predicted result beats, oldest first
    int        beats_queued = 0;
    int        mismatches   = 0;

    function automatic logic signed [31:0] clamp_s32(input logic signed [31:0] v,
                                                     input logic signed [31:0] lo,
                                                     input logic signed [31:0] hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Signed target against the unsigned zoom range
    function automatic logic [15:0] clamp_zoom(input logic [31:0] t);
        longint z, lo, hi;
        z  = longint'($signed(t));
        lo = longint'(zoom_lo);
        hi = longint'(zoom_hi);
        if (z < lo)
            z = lo;
        else if (z > hi)
            z = hi;
        return z[15:0];
    endfunction

    // Decode a closed frame of len bytes, F0 and F7 included
    function automatic frame_verdict_t judge_frame(input int len);
        logic [34:0] v;
        if (len < 7 || !m_hdr_ok)
            return FRAME_QUIET;
        if (len == 7)
            return FRAME_BAD;       // F7 sits where the command would be
        if (m_body[0] != VER_BYTE)
            return FRAME_BAD;
        if (m_body[1] == CAPS_BYTE)
            return FRAME_CAPS;      // any payload length
        if (m_body[1] != SET_BYTE || len != 14)
            return FRAME_BAD;
        v = {m_body[7][6:0], m_body[6][6:0], m_body[5][6:0], m_body[4][6:0], m_body[3][6:0]};
        case (m_body[2])
            {1'b0, CTRL_PAN}:
            begin
                pan_tgt  = v[31:0];
                pt_dirty = 1'b1;
            end
            {1'b0, CTRL_TILT}:
            begin
                tilt_tgt = v[31:0];
                pt_dirty = 1'b1;
            end
            {1'b0, CTRL_ZOOM}:
            begin
                zoom_tgt = v[31:0];
                z_dirty  = 1'b1;
            end
            default:
                return FRAME_BAD;
        endcase
        return FRAME_QUIET;
    endfunction

    // Advance the predictor by one accepted input beat
    task automatic ptz_model_step(input in_item_t beat);
        out_item_t      res [2];
        int             n;
        logic [7:0]     b;
        frame_verdict_t verdict;
        n = 0;
        b = beat.midi_byte;
        if (beat.action) begin
            // flush tick: pan-tilt first, then zoom
            if (pt_dirty) begin
                res[n]          = '0;
                res[n].kind     = KIND_PANTILT;
                res[n].pan_out  = clamp_s32(pan_tgt, pan_lo, pan_hi);
                res[n].tilt_out = clamp_s32(tilt_tgt, tilt_lo, tilt_hi);
                n++;
                pt_dirty = 1'b0;
            end
            if (z_dirty) begin
                res[n]          = '0;
                res[n].kind     = KIND_ZOOM;
                res[n].zoom_out = clamp_zoom(zoom_tgt);
                n++;
                z_dirty = 1'b0;
            end
        end else if (b == SYX_START) begin
            m_in_frame = 1'b1;
            m_count    = 1;
            m_hdr_ok   = 1'b1;
        end else if (m_in_frame && b < RT_FIRST) begin
            // realtime bytes and bytes outside a frame fall through untouched
            if (b == SYX_END) begin
                if (m_count < MAX_FRAME) begin
                    verdict = judge_frame(m_count + 1);
                    if (verdict != FRAME_QUIET) begin
                        res[n]      = '0;
                        res[n].kind = (verdict == FRAME_CAPS) ? KIND_CAPS : KIND_BAD;
                        n++;
                    end
                end
                m_in_frame = 1'b0;
            end else if (b[7]) begin
                m_in_frame = 1'b0;  // status byte aborts the frame
            end else if (m_count < MAX_FRAME) begin
                if (m_count >= 1 && m_count <= 4 && b != PTZ_HDR[m_count - 1])
                    m_hdr_ok = 1'b0;
                if (m_count >= 5 && m_count <= 12)
                    m_body[m_count - 5] = b;
                m_count++;
            end else begin
                m_in_frame = 1'b0;  // oversize: dropped
            end
        end
        for (int i = 0; i < n; i++) begin
            res[i].last = (i == n - 1);
            ptz_results_due.push_back(res[i]);
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: bursts of random length, random gaps, payload held on stall
    // ------------------------------------------------------------------
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end else begin
            if (in_valid && !in_stall)
                ptz_model_step(in_data);
            if (!in_valid || !in_stall) begin
                if (gap_left != 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (pending_beats.size() != 0) begin
                    in_valid <= 1'b1;
                    in_data  <= pending_beats.pop_front();
                    burst_left--;
                    if (burst_left <= 0) begin
                        // mostly short bursts, now and then a long unbroken run
                        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                                 : $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: own stall pattern, field-by-field compare
    // ------------------------------------------------------------------
    int        quiet_left = 20;
    int        hold_left  = 0;
    out_item_t head_result;

    task automatic field_check(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (ptz_results_due.size() == 0) begin
                    $error("result beat with nothing predicted: kind %0d", out_data.kind);
                    mismatches++;
                end else begin
                    head_result = ptz_results_due.pop_front();
                    field_check("kind", 32'(head_result.kind), 32'(out_data.kind));
                    field_check("pan_out", head_result.pan_out, out_data.pan_out);
                    field_check("tilt_out", head_result.tilt_out, out_data.tilt_out);
                    field_check("zoom_out", 32'(head_result.zoom_out), 32'(out_data.zoom_out));
                    field_check("last", 32'(head_result.last), 32'(out_data.last));
                end
            end
            if (quiet_left != 0) begin
                quiet_left--;
                out_stall <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall  <= 1'b0;
                quiet_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
                                                         : $urandom_range(0, 12);
                hold_left  = ($urandom_range(0, 6) == 0) ? $urandom_range(10, 25)
                                                         : $urandom_range(1, 5);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_byte(input logic [7:0] b);
        in_item_t it;
        it.action    = 1'b0;
        it.midi_byte = b;
        pending_beats.push_back(it);
        beats_queued++;
    endtask

    task automatic queue_tick();
        in_item_t it;
        it.action    = 1'b1;
        it.midi_byte = 8'($urandom);  // don't-care on a tick
        pending_beats.push_back(it);
        beats_queued++;
    endtask

    // Header, version, command, then the rest
    function automatic octet_q_t ptz_body(input logic [7:0] ver, input logic [7:0] cmd,
                                          input octet_q_t tail);
        octet_q_t q;
        for (int i = 0; i < 4; i++)
            q.push_back(PTZ_HDR[i]);
        q.push_back(ver);
        q.push_back(cmd);
        foreach (tail[i])
            q.push_back(tail[i]);
        return q;
    endfunction

    // Control byte and value groups, least significant first
    function automatic octet_q_t set_tail(input logic [7:0] ctl, input logic [34:0] v,
                                          input int groups);
        octet_q_t q;
        q.push_back(ctl);
        for (int i = 0; i < groups; i++) begin
            if (i < 5)
                q.push_back({1'b0, v[7*i +: 7]});
            else
                q.push_back({1'b0, 7'($urandom)});
        end
        return q;
    endfunction

    function automatic logic [7:0] pick_control();
        case ($urandom_range(0, 2))
            0:       return {1'b0, CTRL_PAN};
            1:       return {1'b0, CTRL_TILT};
            default: return {1'b0, CTRL_ZOOM};
        endcase
    endfunction

    function automatic logic [34:0] pick_value();
        logic [34:0] v;
        case ($urandom_range(0, 3))
            0: v = {3'($urandom), $urandom};
            1: v = {3'($urandom), 32'($urandom_range(0, 140000)) - 32'd70000};
            2:
            begin
                for (int i = 0; i < 5; i++)
                    v[7*i +: 7] = $urandom_range(0, 1) ? 7'h7F : 7'h00;
            end
            default:
                v = {3'($urandom), ($urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000)
                                   + 32'($urandom_range(0, 4)) - 32'd2};
        endcase
        return v;
    endfunction

    // F0, body with optional realtime bytes mixed in, F7 when closed
    task automatic send_frame(input octet_q_t body, input bit closed, input int rt_pct);
        queue_byte(SYX_START);
        foreach (body[i]) begin
            if ($urandom_range(0, 99) < rt_pct)
                queue_byte(8'($urandom_range(RT_FIRST, 8'hFF)));
            queue_byte(body[i]);
        end
        if (closed)
            queue_byte(SYX_END);
    endtask

    // Caps frame padded with data bytes, for the size limit
    task automatic send_long_caps(input int pad);
        octet_q_t fill;
        for (int i = 0; i < pad; i++)
            fill.push_back(8'($urandom_range(0, 127)));
        send_frame(ptz_body(VER_BYTE, CAPS_BYTE, fill), 1'b1, 0);
    endtask

    // One random traffic event: set frames half the time, else caps, broken frames, noise or ticks
    task automatic queue_random_traffic();
        octet_q_t   none, tail, body;
        int         pick, n;
        logic [7:0] b;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 29) == 0) begin
            // partial frame cut off by a fresh F0
            body = ptz_body(VER_BYTE, SET_BYTE, set_tail(pick_control(), pick_value(), 5));
            n = $urandom_range(0, 12);
            while (body.size() > n)
                void'(body.pop_back());
            send_frame(body, 1'b0, 3);
        end
        if (pick < 50) begin
            send_frame(ptz_body(VER_BYTE, SET_BYTE, set_tail(pick_control(), pick_value(), 5)),
                       1'b1, 3);
        end else if (pick < 58) begin
            n = $urandom_range(0, 4);
            for (int i = 0; i < n; i++)
                tail.push_back(8'($urandom_range(0, 127)));
            send_frame(ptz_body(VER_BYTE, CAPS_BYTE, tail), 1'b1, 3);
        end else if (pick < 61) begin
            b = 8'($urandom_range(0, 127));
            if (b == VER_BYTE)
                b = 8'h00;
            send_frame(ptz_body(b, SET_BYTE, set_tail(pick_control(), pick_value(), 5)),
                       1'b1, 3);
        end else if (pick < 64) begin
            b = 8'($urandom_range(0, 127));
            if (b == CAPS_BYTE || b == SET_BYTE)
                b = 8'h7F;
            send_frame(ptz_body(VER_BYTE, b, set_tail(pick_control(), pick_value(), 5)),
                       1'b1, 3);
        end else if (pick < 67) begin
            n = $urandom_range(0, 8);
            if (n == 5)
                n = 6;
            send_frame(ptz_body(VER_BYTE, SET_BYTE, set_tail(pick_control(), pick_value(), n)),
                       1'b1, 3);
        end else if (pick < 70) begin
            b = 8'($urandom_range(0, 127));
            if (b[6:0] == CTRL_PAN || b[6:0] == CTRL_TILT || b[6:0] == CTRL_ZOOM)
                b = 8'h00;
            send_frame(ptz_body(VER_BYTE, SET_BYTE, set_tail(b, pick_value(), 5)), 1'b1, 3);
        end else if (pick < 74) begin
            // foreign header: one header byte off
            body = ptz_body(VER_BYTE, SET_BYTE, set_tail(pick_control(), pick_value(), 5));
            n = $urandom_range(0, 3);
            b = 8'($urandom_range(0, 127));
            if (b == body[n])
                b = b ^ 8'h01;
            body[n] = b;
            send_frame(body, 1'b1, 3);
        end else if (pick < 76) begin
            // short frame
            body = ptz_body(VER_BYTE, CAPS_BYTE, none);
            n = $urandom_range(0, 4);
            while (body.size() > n)
                void'(body.pop_back());
            send_frame(body, 1'b1, 3);
        end else if (pick < 78) begin
            // seven-byte frame, version byte of any value
            body = ptz_body(VER_BYTE, CAPS_BYTE, none);
            void'(body.pop_back());
            if ($urandom_range(0, 1) == 1)
                body[4] = 8'($urandom_range(0, 127));
            send_frame(body, 1'b1, 3);
        end else if (pick < 82) begin
            // frame aborted by a status byte
            body = ptz_body(VER_BYTE, SET_BYTE, set_tail(pick_control(), pick_value(), 5));
            n = $urandom_range(0, 13);
            while (body.size() > n)
                void'(body.pop_back());
            send_frame(body, 1'b0, 3);
            b = 8'($urandom_range(8'h80, 8'hF6));
            if (b == SYX_START)
                b = 8'h80;
            queue_byte(b);
        end else if (pick < 86) begin
            // stray bytes outside any frame
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++) begin
                b = 8'($urandom);
                if (b == SYX_START)
                    b = SYX_END;
                queue_byte(b);
            end
        end else begin
            queue_tick();
        end
        if ($urandom_range(0, 3) == 0)
            queue_tick();
        if ($urandom_range(0, 299) == 0)
            send_long_caps($urandom_range(245, 252));
    endtask

    // ------------------------------------------------------------------
    // Configuration: only written with the receiver drained
    // ------------------------------------------------------------------
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_beats.size() != 0 || in_valid || ptz_results_due.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic load_ranges(input logic [31:0] plo, input logic [31:0] phi,
                               input logic [31:0] tlo, input logic [31:0] thi,
                               input logic [31:0] zlo, input logic [31:0] zhi);
        logic [31:0]          vals [6];
        logic [CFG_IDX_W-1:0] idx;
        vals = '{plo, phi, tlo, thi, zlo, zhi};
        for (int i = 0; i < 6; i++) begin
            idx = CFG_IDX_W'(i);
            @(posedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= vals[i];
            case (idx)
                CFG_PAN_LOWER:  pan_lo  = vals[i];
                CFG_PAN_UPPER:  pan_hi  = vals[i];
                CFG_TILT_LOWER: tilt_lo = vals[i];
                CFG_TILT_UPPER: tilt_hi = vals[i];
                CFG_ZOOM_LOWER: zoom_lo = vals[i][15:0];
                CFG_ZOOM_UPPER: zoom_hi = vals[i][15:0];
                default:        ;
            endcase
        end
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Run
    // ------------------------------------------------------------------
    initial begin : run
        octet_q_t none, body;
        logic [15:0] junk;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, reset ranges
        queue_tick();                                               // nothing dirty
        send_frame(ptz_body(VER_BYTE, CAPS_BYTE, none), 1'b1, 0);  // caps, no payload
        send_frame(ptz_body(VER_BYTE, CAPS_BYTE, '{8'h12, 8'h34, 8'h7F}), 1'b1, 0);
        body = ptz_body(VER_BYTE, CAPS_BYTE, none);
        void'(body.pop_back());
        send_frame(body, 1'b1, 0);                                  // seven-byte frame
        send_frame('{8'h7D, 8'h50, 8'h54}, 1'b1, 0);                // short frame
        send_frame(ptz_body(8'h02, SET_BYTE, set_tail({1'b0, CTRL_PAN}, 35'd9, 5)), 1'b1, 0);
        send_frame(ptz_body(VER_BYTE, 8'h7F, set_tail({1'b0, CTRL_PAN}, 35'd9, 5)), 1'b1, 0);
        send_frame(ptz_body(VER_BYTE, SET_BYTE, set_tail({1'b0, CTRL_TILT}, 35'd9, 4)),
                   1'b1, 0);
        send_frame(ptz_body(VER_BYTE, SET_BYTE, set_tail({1'b0, CTRL_TILT}, 35'd9, 6)),
                   1'b1, 0);
        send_frame(ptz_body(VER_BYTE, SET_BYTE, set_tail(8'h00, 35'd9, 5)), 1'b1, 0);
        send_frame(ptz_body(VER_BYTE, SET_BYTE, set_tail(8'h7F, 35'd9, 5)), 1'b1, 0);
        body = ptz_body(VER_BYTE, SET_BYTE, set_tail({1'b0, CTRL_PAN}, 35'd9, 5));
        body[3] = 8'h5B;
        send_frame(body, 1'b1, 0);                                  // foreign header
        send_frame(ptz_body(VER_BYTE, SET_BYTE, set_tail({1'b0, CTRL_PAN}, '1, 5)), 1'b1, 0);
        send_frame(ptz_body(VER_BYTE, SET_BYTE,
                            set_tail({1'b0, CTRL_TILT}, 35'h0_8000_0000, 5)), 1'b1, 0);
        send_frame(ptz_body(VER_BYTE, SET_BYTE,
                            set_tail({1'b0, CTRL_ZOOM}, 35'h0_7FFF_FFFF, 5)), 1'b1, 0);
        queue_tick();                                               // two results
        // negative zoom, realtime byte ahead of every byte between F0 and F7
        send_frame(ptz_body(VER_BYTE, SET_BYTE,
                            set_tail({1'b0, CTRL_ZOOM}, 35'h4_FFFF_FFF0, 5)), 1'b1, 100);
        queue_tick();
        // aborted frame, then strays
        send_frame(ptz_body(VER_BYTE, SET_BYTE, set_tail({1'b0, CTRL_PAN}, 35'd5, 2)), 1'b0, 0);
        queue_byte(8'h90);
        queue_byte(SYX_END);
        queue_byte(8'h00);
        queue_byte(8'h7F);
        // F0 in the middle of a frame restarts it
        send_frame(ptz_body(VER_BYTE, SET_BYTE, none), 1'b0, 0);
        send_frame(ptz_body(VER_BYTE, SET_BYTE, set_tail({1'b0, CTRL_PAN}, 35'd1234, 5)),
                   1'b1, 0);
        queue_tick();
        // size limit: last decoded length, F7 at the limit, data byte at the limit
        send_long_caps(MAX_FRAME - 8);
        send_long_caps(MAX_FRAME - 7);
        send_long_caps(MAX_FRAME - 6);

        // Random phases, one range setting each
        for (int phase = 0; phase < PHASES; phase++) begin
            wait_idle();    // sender holds off until every result is in
            junk = 16'($urandom);
            case (phase)
                0: load_ranges(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                               {junk, 16'h0000}, {junk, 16'hFFFF});
                1: load_ranges(32'd0 - 32'($urandom_range(0, 50000)), 32'($urandom_range(0, 50000)),
                               32'd0 - 32'($urandom_range(0, 50000)), 32'($urandom_range(0, 50000)),
                               32'($urandom_range(0, 30000)), 32'($urandom_range(30000, 65535)));
                2: load_ranges(32'd1000, 32'd0 - 32'd1000, 32'd5, 32'd0 - 32'd5,
                               {junk, 16'd40000}, {junk, 16'd100});
                3: load_ranges(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                               {junk, 16'h0000}, {junk, 16'h0000});
                4: load_ranges(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                               {junk, 16'hFFFF}, {junk, 16'hFFFF});
                default: load_ranges($urandom, $urandom, $urandom, $urandom,
                                     $urandom, $urandom);
            endcase
            @(negedge clk);
            beats_queued = 0;
            while (beats_queued < PHASE_BEATS)
                queue_random_traffic();
            queue_tick();   // flush what the phase left dirty
        end

        wait_idle();
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Run limit, far above the slowest legal run
    initial begin : watchdog
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
